// ----- sv/lsd_pkg.sv -----
// ============================================================================
// lsd_pkg: shared types and constants of the lidar scan de-skew unit
// Holds the item kinds, the result status codes and the job word that the
// front end passes to the arithmetic back end.
// ============================================================================
package lsd_pkg;

  // Kind of an input word, carried in tuser.
  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_SEG   = 2'd1,
    FUNC_BEAM  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SAT    = 2'd1;
  localparam logic [1:0] STAT_BEYOND = 2'd2;

  // Width of a segment beam count and of a beam index.
  localparam int unsigned CntW = 13;

  // One beam job, with a snapshot of the poses that it needs.
  typedef struct packed {
    logic                   beyond;
    logic [CntW-1:0]        k;
    logic [CntW-1:0]        d;
    logic signed [23:0]     sx;
    logic signed [23:0]     sy;
    logic signed [15:0]     syaw;
    logic signed [23:0]     ex;
    logic signed [23:0]     ey;
    logic signed [15:0]     eyaw;
    logic signed [23:0]     bx;
    logic signed [23:0]     by;
    logic signed [15:0]     byaw;
    logic [15:0]            rng;
    logic signed [15:0]     bang;
  } job_t;

endpackage

// ----- sv/lsd_front.sv -----
// ============================================================================
// lsd_front: input word decoder and pose state
// Accepts input words, keeps the base and segment poses and the beam index,
// and turns each beam word into a self-contained job for the back end.
// ============================================================================
module lsd_front #(
  parameter int MAX_SEG_BEAMS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lsd_pkg::func_e           func_i,
  input  logic signed [23:0]       pose_x_i,
  input  logic signed [23:0]       pose_y_i,
  input  logic signed [15:0]       pose_yaw_i,
  input  logic [12:0]              seg_beams_i,
  input  logic [15:0]              beam_range_i,
  input  logic signed [15:0]       beam_angle_i,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output lsd_pkg::job_t            job_o
);

  localparam int MaxN = (MAX_SEG_BEAMS > 8191) ? 8191 : MAX_SEG_BEAMS;
  localparam logic [12:0] MaxNV = 13'(MaxN);

  logic signed [23:0] base_x_q, base_y_q, st_x_q, st_y_q, en_x_q, en_y_q;
  logic signed [15:0] base_hdg_q, st_yaw_q, en_yaw_q;
  logic [12:0]        cnt_q, step_q, n_clamped;
  logic [13:0]        k_wide;
  logic               accept, beyond;

  // A word is taken only when the job queue has room.
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;

  assign k_wide = {1'b0, step_q} + 14'd1;
  assign beyond = k_wide >= {1'b0, cnt_q};

  always_comb begin
    n_clamped = seg_beams_i;
    if (seg_beams_i < 13'd2) begin
      n_clamped = 13'd2;
    end else if (seg_beams_i > MaxNV) begin
      n_clamped = MaxNV;
    end
  end

  // Beam jobs carry the pose snapshot; frame and segment words only change state.
  assign job_valid_o = in_valid_i && (func_i == lsd_pkg::FUNC_BEAM);
  always_comb begin
    job_o.beyond = beyond;
    job_o.k      = k_wide[12:0];
    job_o.d      = cnt_q - 13'd1;
    job_o.sx     = st_x_q;
    job_o.sy     = st_y_q;
    job_o.syaw   = st_yaw_q;
    job_o.ex     = en_x_q;
    job_o.ey     = en_y_q;
    job_o.eyaw   = en_yaw_q;
    job_o.bx     = base_x_q;
    job_o.by     = base_y_q;
    job_o.byaw   = base_hdg_q;
    job_o.rng    = beam_range_i;
    job_o.bang   = beam_angle_i;
  end

  // Pose and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0; base_y_q <= '0; base_hdg_q <= '0;
      st_x_q <= '0; st_y_q <= '0; st_yaw_q <= '0;
      en_x_q <= '0; en_y_q <= '0; en_yaw_q <= '0;
      cnt_q <= 13'd2;
      step_q <= '0;
    end else if (accept) begin
      case (func_i)
        lsd_pkg::FUNC_FRAME: begin
          base_x_q <= pose_x_i; base_y_q <= pose_y_i; base_hdg_q <= pose_yaw_i;
          st_x_q <= pose_x_i; st_y_q <= pose_y_i; st_yaw_q <= pose_yaw_i;
          en_x_q <= pose_x_i; en_y_q <= pose_y_i; en_yaw_q <= pose_yaw_i;
          cnt_q <= 13'd2;
          step_q <= '0;
        end
        lsd_pkg::FUNC_SEG: begin
          st_x_q <= en_x_q; st_y_q <= en_y_q; st_yaw_q <= en_yaw_q;
          en_x_q <= pose_x_i; en_y_q <= pose_y_i; en_yaw_q <= pose_yaw_i;
          cnt_q <= n_clamped;
          step_q <= '0;
        end
        lsd_pkg::FUNC_BEAM: begin
          if (!beyond) begin
            step_q <= k_wide[12:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/lsd_queue.sv -----
// ============================================================================
// lsd_queue: two-entry job queue
// Decouples the front end from the back end so that each may stall alone.
// ============================================================================
module lsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  lsd_pkg::job_t  job_i,
  output logic           valid_o,
  input  logic           pop_i,
  output lsd_pkg::job_t  job_o,
  output logic [1:0]     level_o
);

  lsd_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    lvl_q;
  logic          do_push, do_pop;

  assign full_o  = lvl_q == 2'd2;
  assign valid_o = lvl_q != 2'd0;
  assign job_o   = mem_q[rd_q];
  assign level_o = lvl_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage for the words.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; lvl_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        lvl_q <= lvl_q + 2'd1;
      end else if (do_pop && !do_push) begin
        lvl_q <= lvl_q - 2'd1;
      end
    end
  end

endmodule

// ----- sv/lsd_back.sv -----
// ============================================================================
// lsd_back: beam arithmetic engine
// Interpolates the pose with three bit-serial dividers, rotates the beam and
// the pose offset with two CORDIC lanes, converts the sum back to polar form
// and removes the CORDIC gain with a split multiply. Holds the output word.
// ============================================================================
module lsd_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  input  lsd_pkg::job_t       job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         out_range_o,
  output logic signed [15:0]  out_angle_o,
  output logic [1:0]          status_o
);

  localparam int          NumW   = 47;
  localparam int          W      = 44;
  localparam logic [5:0]  DivEnd = 6'(NumW - 1);
  localparam logic [5:0]  CorEnd = 6'(CORDIC_STEPS - 1);
  localparam logic [28:0] InvGain = 29'd395948877;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_LOAD, S_DIV, S_LOAD, S_ROT, S_SUM, S_VEC, S_MUL0, S_MUL1, S_FIN, S_DONE
  } state_e;

  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E; 5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4; 5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55; 5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  state_e                state_q;
  lsd_pkg::job_t         job_q;
  logic [5:0]            cnt_q;
  logic [NumW-1:0]       dvd_q [3];
  logic [13:0]           rem_q [3];
  logic                  neg_q [3];
  logic signed [W-1:0]   xa_q, ya_q, xd_q, yd_q;
  logic [31:0]           za_q, zd_q;
  logic                  zero_q;
  logic [50:0]           plo_q, phi_q;
  logic [15:0]           rng_q, ang_q;
  logic [1:0]            st_q;
  logic [15:0]           res_rng_q, res_ang_q;
  logic [1:0]            res_st_q;
  logic                  ov_q;

  // Divider lane inputs: differences and their magnitudes.
  logic signed [24:0]    dif [3];
  logic [24:0]           dmag [3];
  logic [37:0]           prod [3];
  logic [NumW-1:0]       num [3];
  logic [13:0]           rsh [3];
  logic                  qbit [3];

  always_comb begin
    dif[0] = 25'(job_q.ex) - 25'(job_q.sx);
    dif[1] = 25'(job_q.ey) - 25'(job_q.sy);
    dif[2] = 25'(job_q.eyaw) - 25'(job_q.syaw);
    for (int l = 0; l < 3; l++) begin
      dmag[l] = dif[l][24] ? 25'(-dif[l]) : 25'(dif[l]);
      prod[l] = 38'(dmag[l]) * 38'(job_q.k);
    end
    num[0] = NumW'({prod[0], 6'd0}) + NumW'(job_q.d >> 1);
    num[1] = NumW'({prod[1], 6'd0}) + NumW'(job_q.d >> 1);
    num[2] = NumW'({prod[2], 16'd0}) + NumW'(job_q.d >> 1);
    for (int l = 0; l < 3; l++) begin
      rsh[l]  = {rem_q[l][12:0], dvd_q[l][NumW-1]};
      qbit[l] = rsh[l] >= {1'b0, job_q.d};
    end
  end

  // Interpolated pose and rotation inputs.
  logic signed [47:0] tx, ty, yk, st48 [3], q48 [3];
  logic signed [47:0] dx, dy;
  logic [31:0]        phi, bturn, za0;
  logic               fa;

  always_comb begin
    st48[0] = 48'(job_q.sx) <<< 6;
    st48[1] = 48'(job_q.sy) <<< 6;
    st48[2] = 48'(job_q.syaw) <<< 16;
    for (int l = 0; l < 3; l++) begin
      q48[l] = 48'(dvd_q[l]);
    end
    tx = neg_q[0] ? st48[0] - q48[0] : st48[0] + q48[0];
    ty = neg_q[1] ? st48[1] - q48[1] : st48[1] + q48[1];
    yk = neg_q[2] ? st48[2] - q48[2] : st48[2] + q48[2];
    dx = tx - (48'(job_q.bx) <<< 6);
    dy = ty - (48'(job_q.by) <<< 6);
    bturn = {job_q.byaw, 16'd0};
    phi = yk[31:0] + {job_q.bang, 16'd0} - bturn;
    za0 = 32'd0 - bturn;
    fa  = 1'(((phi + 32'h40000000) >> 31));
  end

  logic fd;
  assign fd = 1'(((za0 + 32'h40000000) >> 31));

  // One CORDIC iteration of each lane.
  logic [4:0]          it;
  logic signed [W-1:0] sxs, sys;
  logic [73:0]         acc;
  assign it  = cnt_q[4:0];
  assign sxs = xa_q + xd_q;
  assign sys = ya_q + yd_q;
  assign acc = (74'(phi_q) << 22) + 74'(plo_q) + (74'(1) << 35);

  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign out_valid_o = ov_q;
  assign out_range_o = rng_q;
  assign out_angle_o = ang_q;
  assign status_o    = st_q;

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && (state_q != S_DONE)) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            if (job_i.beyond) begin
              res_rng_q <= '0; res_ang_q <= '0; res_st_q <= lsd_pkg::STAT_BEYOND;
              state_q <= S_DONE;
            end else begin
              state_q <= S_DIV_LOAD;
            end
          end
        end
        S_DIV_LOAD: begin
          for (int l = 0; l < 3; l++) begin
            dvd_q[l] <= num[l];
            rem_q[l] <= '0;
            neg_q[l] <= dif[l][24];
          end
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          for (int l = 0; l < 3; l++) begin
            rem_q[l] <= qbit[l] ? rsh[l] - {1'b0, job_q.d} : rsh[l];
            dvd_q[l] <= {dvd_q[l][NumW-2:0], qbit[l]};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == DivEnd) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          xa_q <= fa ? -(W'(job_q.rng) <<< 6) : (W'(job_q.rng) <<< 6);
          ya_q <= '0;
          za_q <= fa ? phi + 32'h80000000 : phi;
          xd_q <= fd ? W'(-dx) : W'(dx);
          yd_q <= fd ? W'(-dy) : W'(dy);
          zd_q <= fd ? za0 + 32'h80000000 : za0;
          cnt_q   <= '0;
          state_q <= S_ROT;
        end
        S_ROT: begin
          if (!za_q[31]) begin
            xa_q <= xa_q - (ya_q >>> it); ya_q <= ya_q + (xa_q >>> it);
            za_q <= za_q - atan_at(it);
          end else begin
            xa_q <= xa_q + (ya_q >>> it); ya_q <= ya_q - (xa_q >>> it);
            za_q <= za_q + atan_at(it);
          end
          if (!zd_q[31]) begin
            xd_q <= xd_q - (yd_q >>> it); yd_q <= yd_q + (xd_q >>> it);
            zd_q <= zd_q - atan_at(it);
          end else begin
            xd_q <= xd_q + (yd_q >>> it); yd_q <= yd_q - (xd_q >>> it);
            zd_q <= zd_q + atan_at(it);
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == CorEnd) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          zero_q <= (sxs == '0) && (sys == '0);
          xa_q <= sxs[W-1] ? -sxs : sxs;
          ya_q <= sxs[W-1] ? -sys : sys;
          za_q <= sxs[W-1] ? 32'h80000000 : 32'd0;
          cnt_q   <= '0;
          state_q <= S_VEC;
        end
        S_VEC: begin
          if (!ya_q[W-1]) begin
            xa_q <= xa_q + (ya_q >>> it); ya_q <= ya_q - (xa_q >>> it);
            za_q <= za_q + atan_at(it);
          end else begin
            xa_q <= xa_q - (ya_q >>> it); ya_q <= ya_q + (xa_q >>> it);
            za_q <= za_q - atan_at(it);
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == CorEnd) begin
            state_q <= S_MUL0;
          end
        end
        S_MUL0: begin
          plo_q   <= 51'(xa_q[21:0]) * 51'(InvGain);
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          phi_q   <= 51'(xa_q[W-1:22]) * 51'(InvGain);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (zero_q) begin
            res_rng_q <= '0; res_ang_q <= '0; res_st_q <= lsd_pkg::STAT_OK;
          end else begin
            res_ang_q <= 16'((za_q + 32'h8000) >> 16);
            if (acc[73:52] != '0) begin
              res_rng_q <= 16'hFFFF; res_st_q <= lsd_pkg::STAT_SAT;
            end else begin
              res_rng_q <= acc[51:36]; res_st_q <= lsd_pkg::STAT_OK;
            end
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // The finished word moves to the output once that register is free.
          if (!ov_q || out_ready_i) begin
            rng_q   <= res_rng_q;
            ang_q   <= res_ang_q;
            st_q    <= res_st_q;
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/lidar_scan_deskew_unit.sv -----
// ============================================================================
// lidar_scan_deskew_unit: lidar scan motion de-skew
// Corrects each beam for sensor motion by linear pose interpolation across a
// segment and returns it in polar form relative to the frame's base pose.
// ============================================================================
// Frame and segment words update the pose state and give no word out. A
// beam word is queued (two entries) and handled by one shared arithmetic
// engine, one beam at a time, through the 47-step bit-serial pose
// interpolation dividers and the two CORDIC passes. A beam beyond the
// segment count goes straight to the output register without arithmetic.
// Results wait in that register, so the engine starts the next beam while
// one is still pending.
module lidar_scan_deskew_unit #(
  parameter int CORDIC_STEPS  = 16,
  parameter int MAX_SEG_BEAMS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [23:0] pose_x, [47:24] pose_y, [63:48] pose_yaw, [76:64] seg_beams,
  // [92:77] beam_range, [108:93] beam_angle, [111:109] zero
  input  logic [111:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [15:0] out_range, [31:16] out_angle
  output logic [31:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]   m_axis_tuser_o
);

  logic          job_valid, q_full, q_valid, q_pop;
  logic [1:0]    q_level;
  lsd_pkg::job_t job_in, job_out;
  logic [15:0]   rng;
  logic signed [15:0] ang;

  lsd_front #(.MAX_SEG_BEAMS(MAX_SEG_BEAMS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .func_i       (lsd_pkg::func_e'(s_axis_tuser_i)),
    .pose_x_i     (s_axis_tdata_i[23:0]),
    .pose_y_i     (s_axis_tdata_i[47:24]),
    .pose_yaw_i   (s_axis_tdata_i[63:48]),
    .seg_beams_i  (s_axis_tdata_i[76:64]),
    .beam_range_i (s_axis_tdata_i[92:77]),
    .beam_angle_i (s_axis_tdata_i[108:93]),
    .job_valid_o  (job_valid),
    .job_ready_i  (!q_full),
    .job_o        (job_in)
  );

  lsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .full_o  (q_full),
    .job_i   (job_in),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .level_o (q_level)
  );

  lsd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_i       (job_out),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_range_o (rng),
    .out_angle_o (ang),
    .status_o    (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {ang, rng};

`ifndef SYNTHESIS
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level != 2'd3) else $error("job queue level out of range");
  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == lsd_pkg::STAT_SAT) |->
    m_axis_tdata_o[15:0] == 16'hFFFF) else $error("saturated word without full range");
  a_beyond_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == lsd_pkg::STAT_BEYOND) |->
    m_axis_tdata_o == 32'd0) else $error("beyond-count word carries data");
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_level == 2'd2) |-> !s_axis_tready_o) else $error("input taken with queue full");
`endif

endmodule

// ----- sim/lsd_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lsd_checker: prediction and comparison for the lidar scan de-skew unit
// Watches both stream channels, keeps its own copy of the pose state, and
// works out the corrected range, bearing and status of every beam word. Each
// output word is compared field by field with the oldest expected word.
// ============================================================================
module lsd_checker #(
  parameter int CORDIC_STEPS  = 16,
  parameter int MAX_SEG_BEAMS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [111:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [31:0]  m_axis_tdata_i,
  input  logic [1:0]   m_axis_tuser_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           beams_o,
  output int           saturated_o,
  output int           beyond_o
);

  localparam longint InvGainSq = 64'd395948877;

  typedef struct packed {
    logic [15:0] rng;
    logic [15:0] ang;
    logic [1:0]  stat;
  } beam_word_t;

  beam_word_t corrected_q[$];

  // Pose state as the block holds it.
  logic signed [23:0] base_x, base_y, start_x, start_y, end_x, end_y;
  logic signed [15:0] frame_hdg, seg0_hdg, end_yaw;
  int unsigned        beam_count, beam_idx;

  function automatic int unsigned cordic_len();
    return (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  endfunction

  function automatic logic [31:0] atan_step(int i);
    case (i)
      0: return 32'h20000000;   1: return 32'h12E4051E;   2: return 32'h09FB385B;
      3: return 32'h051111D4;   4: return 32'h028B0D43;   5: return 32'h0145D7E1;
      6: return 32'h00A2F61E;   7: return 32'h00517C55;   8: return 32'h0028BE53;
      9: return 32'h00145F2F;  10: return 32'h000A2F98;  11: return 32'h000517CC;
      12: return 32'h00028BE6; 13: return 32'h000145F3;  14: return 32'h0000A2FA;
      15: return 32'h0000517D; 16: return 32'h000028BE;  17: return 32'h0000145F;
      18: return 32'h00000A30; 19: return 32'h00000518;  20: return 32'h0000028C;
      21: return 32'h00000146; 22: return 32'h000000A3;  default: return 32'h00000051;
    endcase
  endfunction

  // Linear interpolation at k/d, rounding half away from zero.
  function automatic longint lerp(longint a, longint b, int unsigned k, int unsigned d);
    longint num, mag, q;
    num = (b - a) * longint'(k);
    mag = (num < 0) ? -num : num;
    q   = (mag + longint'(d / 2)) / longint'(d);
    return (num < 0) ? a - q : a + q;
  endfunction

  function automatic void cordic_rotate(inout longint x, inout longint y, input logic [31:0] z);
    longint nx, ny;
    logic [31:0] t;
    t = z + 32'h40000000;
    if (t[31]) begin
      x = -x;
      y = -y;
      z = z + 32'h80000000;
    end
    for (int i = 0; i < cordic_len(); i++) begin
      if (!z[31]) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_step(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_step(i);
      end
      x = nx;
      y = ny;
    end
  endfunction

  function automatic longint cordic_vector(longint x, longint y, output logic [31:0] ang);
    longint nx, ny;
    ang = '0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      ang = 32'h80000000;
    end
    for (int i = 0; i < cordic_len(); i++) begin
      if (y >= 0) begin
        nx  = x + (y >>> i);
        ny  = y - (x >>> i);
        ang = ang + atan_step(i);
      end else begin
        nx  = x - (y >>> i);
        ny  = y + (x >>> i);
        ang = ang - atan_step(i);
      end
      x = nx;
      y = ny;
    end
    return x;
  endfunction

  // Corrected polar point of one beam; advances the beam index unless the beam is beyond the count.
  function automatic beam_word_t deskew_beam(logic [15:0] rng, logic signed [15:0] bang);
    beam_word_t  res;
    int unsigned k, d;
    longint      tx, ty, yk, ax, ay, dx, dy, sx, sy, mag;
    logic [31:0] bturn, phi, ang;
    logic [63:0] r;
    res = '0;
    if (beam_idx + 1 >= beam_count) begin
      res.stat = lsd_pkg::STAT_BEYOND;
      return res;
    end
    k     = beam_idx + 1;
    d     = beam_count - 1;
    tx    = lerp(longint'(start_x) * 64, longint'(end_x) * 64, k, d);
    ty    = lerp(longint'(start_y) * 64, longint'(end_y) * 64, k, d);
    yk    = lerp(longint'(seg0_hdg) * 65536, longint'(end_yaw) * 65536, k, d);
    bturn = {frame_hdg, 16'h0000};
    phi   = yk[31:0] + {bang, 16'h0000} - bturn;
    ax    = longint'(rng) * 64;
    ay    = 0;
    dx    = tx - longint'(base_x) * 64;
    dy    = ty - longint'(base_y) * 64;
    cordic_rotate(ax, ay, phi);
    cordic_rotate(dx, dy, 32'h0 - bturn);
    sx = ax + dx;
    sy = ay + dy;
    ang = '0;
    r   = '0;
    if (sx != 0 || sy != 0) begin
      mag = cordic_vector(sx, sy, ang);
      r   = (64'(mag) * 64'(InvGainSq) + (64'd1 << 35)) >> 36;
    end
    res.stat = lsd_pkg::STAT_OK;
    if (r > 64'd65535) begin
      r        = 64'd65535;
      res.stat = lsd_pkg::STAT_SAT;
    end
    res.rng  = r[15:0];
    ang      = ang + 32'h8000;
    res.ang  = ang[31:16];
    beam_idx = k;
    return res;
  endfunction

  assign pending_o = corrected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lsd_pkg::func_e     f;
    logic [12:0]        nb;
    int unsigned        n;
    beam_word_t         want, got;
    if (!rst_ni) begin
      base_x = '0; base_y = '0; frame_hdg = '0;
      start_x = '0; start_y = '0; seg0_hdg = '0;
      end_x = '0; end_y = '0; end_yaw = '0;
      beam_count = 2;
      beam_idx = 0;
      corrected_q.delete();
      fail_count_o = 0;
      beams_o = 0;
      saturated_o = 0;
      beyond_o = 0;
    end else begin
      // Input word: update the pose state or predict a beam.
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        f = lsd_pkg::func_e'(s_axis_tuser_i);
        case (f)
          lsd_pkg::FUNC_FRAME: begin
            base_x = s_axis_tdata_i[23:0];  start_x = base_x;  end_x = base_x;
            base_y = s_axis_tdata_i[47:24]; start_y = base_y;  end_y = base_y;
            frame_hdg = s_axis_tdata_i[63:48];
            seg0_hdg = frame_hdg;
            end_yaw = frame_hdg;
            beam_count = 2;
            beam_idx = 0;
          end
          lsd_pkg::FUNC_SEG: begin
            nb = s_axis_tdata_i[76:64];
            n  = (nb < 2) ? 2 : (nb > MAX_SEG_BEAMS) ? MAX_SEG_BEAMS : nb;
            start_x = end_x; start_y = end_y; seg0_hdg = end_yaw;
            end_x = s_axis_tdata_i[23:0];
            end_y = s_axis_tdata_i[47:24];
            end_yaw = s_axis_tdata_i[63:48];
            beam_count = n;
            beam_idx = 0;
          end
          lsd_pkg::FUNC_BEAM: begin
            want = deskew_beam(s_axis_tdata_i[92:77], s_axis_tdata_i[108:93]);
            corrected_q.insert(corrected_q.size(), want);
          end
          default: ;
        endcase
      end
      // Output word: compare with the oldest prediction.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.rng  = m_axis_tdata_i[15:0];
        got.ang  = m_axis_tdata_i[31:16];
        got.stat = m_axis_tuser_i;
        if (corrected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 20)
            $display("%0t: unexpected word, range %0d angle %0d status %0d",
                     $time, got.rng, $signed(got.ang), got.stat);
        end else begin
          want = corrected_q.pop_front();
          beams_o++;
          if (want.stat == lsd_pkg::STAT_SAT) saturated_o++;
          if (want.stat == lsd_pkg::STAT_BEYOND) beyond_o++;
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 20)
              $display("%0t: mismatch, expected range %0d angle %0d status %0d, got range %0d angle %0d status %0d",
                       $time, want.rng, $signed(want.ang), want.stat,
                       got.rng, $signed(got.ang), got.stat);
          end
        end
      end
    end
  end

endmodule

// ----- sim/lidar_scan_deskew_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lidar_scan_deskew_unit_tb: stimulus and verdict for the de-skew unit
// Drives directed frame, segment and beam words, then random scan sequences
// under three idling patterns and one long output stall; the checker beside
// the block predicts every beam and counts mismatches.
// ============================================================================
module lidar_scan_deskew_unit_tb;

  localparam int WatchdogLimit = 20000;
  localparam int StallCycles   = 3000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid, s_tready, m_tvalid, m_tready;
  logic [111:0] s_tdata;
  logic [1:0]   s_tuser, m_tuser;
  logic [31:0]  m_tdata;

  int fail_count, pending, beams, saturated, beyond;
  int in_words, out_words, quiet_cycles;
  int snd_idle_pct, rcv_idle_pct;
  int words_sent;
  bit stall_request;

  // Current pose of the random scan walk.
  logic signed [23:0] walk_x, walk_y;
  logic signed [15:0] walk_yaw;

  lidar_scan_deskew_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  lsd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .beams_o         (beams),
    .saturated_o     (saturated),
    .beyond_o        (beyond)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Word counters and the watchdog on accepted words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_words <= 0;
      out_words <= 0;
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) in_words <= in_words + 1;
      if (m_tvalid && m_tready) out_words <= out_words + 1;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout after %0d cycles with no word accepted", WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random ready, with one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        m_tready <= 1'b0;
        repeat (StallCycles) @(negedge clk_i);
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offers one word and waits for it to be taken; valid drops only in a gap.
  task automatic send_word(lsd_pkg::func_e f, logic [23:0] x, logic [23:0] y,
                           logic [15:0] yaw, logic [12:0] n, logic [15:0] rng,
                           logic [15:0] ang);
    int target;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    s_tdata  <= {3'b000, ang, rng, n, yaw, y, x};
    s_tuser  <= f;
    s_tvalid <= 1'b1;
    target = in_words + 1;
    do @(negedge clk_i); while (in_words != target);
    if (f != lsd_pkg::FUNC_NONE) words_sent++;
  endtask

  task automatic send_beam(logic [15:0] rng, logic [15:0] ang);
    send_word(lsd_pkg::FUNC_BEAM, 24'($urandom), 24'($urandom), 16'($urandom),
              13'($urandom), rng, ang);
  endtask

  // Next pose of the walk: mostly a small step, sometimes anywhere.
  task automatic step_pose();
    if ($urandom_range(99) < 10) begin
      walk_x = 24'($urandom);
      walk_y = 24'($urandom);
      walk_yaw = 16'($urandom);
    end else begin
      walk_x = walk_x + 24'($signed($urandom_range(4000)) - 2000);
      walk_y = walk_y + 24'($signed($urandom_range(4000)) - 2000);
      walk_yaw = walk_yaw + 16'($signed($urandom_range(8000)) - 4000);
    end
  endtask

  // Random scans: frames, segments followed by their beams, and some noise.
  task automatic run_scans(int count);
    int stop_at, sel, nb, beams_left;
    logic [12:0] n;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        step_pose();
        send_word(lsd_pkg::FUNC_FRAME, walk_x, walk_y, walk_yaw, 13'($urandom),
                  16'($urandom), 16'($urandom));
      end else if (sel < 9) begin
        send_word(lsd_pkg::FUNC_NONE, 24'($urandom), 24'($urandom), 16'($urandom),
                  13'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 12) begin
        send_beam(16'($urandom), 16'($urandom));
      end else begin
        step_pose();
        sel = $urandom_range(99);
        if (sel < 4) n = 13'($urandom);
        else if (sel < 7) n = 13'($urandom_range(1));
        else n = 13'($urandom_range(2, 10));
        send_word(lsd_pkg::FUNC_SEG, walk_x, walk_y, walk_yaw, n, 16'($urandom),
                  16'($urandom));
        nb = (n < 2) ? 1 : n - 1;
        beams_left = (nb > 6) ? 6 : nb + $urandom_range(1);
        repeat (beams_left) begin
          if ($urandom_range(9) < 7) send_beam(16'($urandom_range(20000)), 16'($urandom));
          else send_beam(16'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = lsd_pkg::FUNC_NONE;
    snd_idle_pct = 8;
    rcv_idle_pct = 84;
    stall_request = 1'b0;
    words_sent = 0;
    walk_x = '0;
    walk_y = '0;
    walk_yaw = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: beams on the reset state, extremes, clamping and special cases.
    send_beam(16'd1000, 16'h4000);
    send_beam(16'd1000, 16'h4000);
    send_word(lsd_pkg::FUNC_FRAME, 24'h7FFFFF, 24'h800000, 16'h7FFF, 13'd0, 16'd0, 16'd0);
    send_word(lsd_pkg::FUNC_SEG, 24'h800000, 24'h7FFFFF, 16'h8000, 13'd3, 16'd0, 16'd0);
    send_beam(16'hFFFF, 16'h7FFF);
    send_beam(16'd0, 16'h8000);
    send_beam(16'd5, 16'd0);
    send_word(lsd_pkg::FUNC_FRAME, 24'd0, 24'd0, 16'd0, 13'd0, 16'd0, 16'd0);
    send_word(lsd_pkg::FUNC_SEG, 24'd0, 24'd0, 16'd0, 13'd0, 16'd0, 16'd0);
    send_beam(16'd0, 16'h1234);
    send_beam(16'd0, 16'd0);
    send_word(lsd_pkg::FUNC_SEG, 24'd5000, 24'hFFEC78, 16'h2000, 13'd1, 16'd0, 16'd0);
    send_beam(16'hFFFF, 16'h0000);
    send_word(lsd_pkg::FUNC_SEG, 24'd100, 24'd200, 16'hE000, 13'd8191, 16'd0, 16'd0);
    send_beam(16'd5000, 16'hC000);
    send_word(lsd_pkg::FUNC_SEG, 24'd300, 24'd200, 16'hE100, 13'd4096, 16'd0, 16'd0);
    send_beam(16'd65535, 16'h5555);
    send_word(lsd_pkg::FUNC_SEG, 24'd400, 24'd100, 16'hE200, 13'd2, 16'd0, 16'd0);
    send_beam(16'd1, 16'hAAAA);
    send_beam(16'd1, 16'hAAAA);
    send_word(lsd_pkg::FUNC_NONE, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 13'h1FFF, 16'hFFFF,
              16'hFFFF);

    // Random scans under the three idling patterns.
    run_scans(300);
    snd_idle_pct = 84;
    rcv_idle_pct = 8;
    run_scans(300);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    stall_request = 1'b1;
    run_scans(300);

    s_tvalid <= 1'b0;
    drain();
    $display("Sent %0d words; checked %0d beam results (%0d saturated, %0d beyond count).",
             words_sent, beams, saturated, beyond);
    $display("Covered frames, clamped segment counts, ignored words and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lsd_pkg.sv
sv/lsd_front.sv
sv/lsd_queue.sv
sv/lsd_back.sv
sv/lidar_scan_deskew_unit.sv
sim/lsd_checker.sv
sim/lidar_scan_deskew_unit_tb.sv
